// File: rtl/core/jsu_pkg.sv
package jsu_pkg;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    localparam int CP_W = 21;

    // kinds of result transaction
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NO_QUOTE   = 3'd0,
        ERR_CONTROL    = 3'd1,
        ERR_BAD_ESCAPE = 3'd2,
        ERR_BAD_HEX    = 3'd3,
        ERR_LONE_LOW   = 3'd4,
        ERR_MISSING_U  = 3'd5,
        ERR_BAD_LOW    = 3'd6,
        ERR_ENDED      = 3'd7
    } err_t;

    // commands handed from the front to the back
    typedef enum logic [1:0] {
        OP_BYTE       = 2'd0,
        OP_CODE_POINT = 2'd1,
        OP_END        = 2'd2,
        OP_ERROR      = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CP_W-1:0]  cp;
        err_t             code;
    } cmd_t;

endpackage

// File: rtl/core/jsu_front.sv
module jsu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          end_of_input,
    output logic          push,
    output jsu_pkg::cmd_t cmd
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_STRING  = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_HEX1    = 3'd3,
        PH_WANT_BS = 3'd4,
        PH_WANT_U  = 3'd5,
        PH_HEX2    = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [15:0] hex_accum_reg, hex_accum_next;
    logic [9:0]  high_bits_reg, high_bits_next;

    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic [15:0] hex_full;

    // hex digit decode
    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (data_byte inside {["0":"9"]})
        begin
            hex_digit = 4'(data_byte - 8'h30);
        end
        else if (data_byte inside {["a":"f"]})
        begin
            hex_digit = 4'(data_byte - 8'h57);
        end
        else if (data_byte inside {["A":"F"]})
        begin
            hex_digit = 4'(data_byte - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign hex_full = {hex_accum_reg[11:0], hex_digit};

    // parser step for one accepted byte
    always_comb
    begin
        phase_next       = phase_reg;
        digit_count_next = digit_count_reg;
        hex_accum_next   = hex_accum_reg;
        high_bits_next   = high_bits_reg;
        push             = 1'b0;
        cmd.op           = OP_BYTE;
        cmd.cp           = CP_W'(data_byte);
        cmd.code         = ERR_NO_QUOTE;

        if (end_of_input)
        begin
            push     = 1'b1;
            cmd.op   = OP_ERROR;
            cmd.code = (phase_reg == PH_IDLE || phase_reg > PH_HEX2) ? ERR_NO_QUOTE
                                                                      : ERR_ENDED;
        end
        else
        begin
            case (phase_reg)
                PH_STRING:
                begin
                    if (data_byte == "\"")
                    begin
                        push       = 1'b1;
                        cmd.op     = OP_END;
                        phase_next = PH_IDLE;
                    end
                    else if (data_byte < 8'h20)
                    begin
                        push     = 1'b1;
                        cmd.op   = OP_ERROR;
                        cmd.code = ERR_CONTROL;
                    end
                    else if (data_byte == "\\")
                    begin
                        phase_next = PH_ESCAPE;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                PH_ESCAPE:
                begin
                    push       = 1'b1;
                    phase_next = PH_STRING;
                    case (data_byte)
                        "\"", "\\", "/": cmd.cp = CP_W'(data_byte);
                        "b":             cmd.cp = CP_W'(8'h08);
                        "f":             cmd.cp = CP_W'(8'h0C);
                        "n":             cmd.cp = CP_W'(8'h0A);
                        "r":             cmd.cp = CP_W'(8'h0D);
                        "t":             cmd.cp = CP_W'(8'h09);
                        "u":
                        begin
                            push             = 1'b0;
                            phase_next       = PH_HEX1;
                            digit_count_next = 2'd0;
                            hex_accum_next   = 16'd0;
                        end
                        default:
                        begin
                            cmd.op   = OP_ERROR;
                            cmd.code = ERR_BAD_ESCAPE;
                        end
                    endcase
                end
                PH_WANT_BS:
                begin
                    if (data_byte == "\\")
                    begin
                        phase_next = PH_WANT_U;
                    end
                    else
                    begin
                        push     = 1'b1;
                        cmd.op   = OP_ERROR;
                        cmd.code = ERR_MISSING_U;
                    end
                end
                PH_WANT_U:
                begin
                    if (data_byte == "u")
                    begin
                        phase_next       = PH_HEX2;
                        digit_count_next = 2'd0;
                        hex_accum_next   = 16'd0;
                    end
                    else
                    begin
                        push     = 1'b1;
                        cmd.op   = OP_ERROR;
                        cmd.code = ERR_MISSING_U;
                    end
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (!hex_ok)
                    begin
                        push     = 1'b1;
                        cmd.op   = OP_ERROR;
                        cmd.code = ERR_BAD_HEX;
                    end
                    else if (digit_count_reg != 2'd3)
                    begin
                        hex_accum_next   = hex_full;
                        digit_count_next = digit_count_reg + 2'd1;
                    end
                    else
                    begin
                        digit_count_next = 2'd0;
                        hex_accum_next   = 16'd0;
                        if (phase_reg == PH_HEX1)
                        begin
                            // high surrogate waits for its partner
                            if (hex_full[15:10] == 6'b110110)
                            begin
                                high_bits_next = hex_full[9:0];
                                phase_next     = PH_WANT_BS;
                            end
                            else if (hex_full[15:10] == 6'b110111)
                            begin
                                push     = 1'b1;
                                cmd.op   = OP_ERROR;
                                cmd.code = ERR_LONE_LOW;
                            end
                            else
                            begin
                                push       = 1'b1;
                                cmd.op     = OP_CODE_POINT;
                                cmd.cp     = CP_W'(hex_full);
                                phase_next = PH_STRING;
                            end
                        end
                        else
                        begin
                            if (hex_full[15:10] != 6'b110111)
                            begin
                                push     = 1'b1;
                                cmd.op   = OP_ERROR;
                                cmd.code = ERR_BAD_LOW;
                            end
                            else
                            begin
                                // join the pair into one code point
                                push           = 1'b1;
                                cmd.op         = OP_CODE_POINT;
                                cmd.cp         = CP_W'(21'h10000) +
                                                 CP_W'({high_bits_reg, hex_full[9:0]});
                                high_bits_next = 10'd0;
                                phase_next     = PH_STRING;
                            end
                        end
                    end
                end
                default:
                begin
                    // idle: skip blanks, wait for the opening quote
                    if (data_byte == "\"")
                    begin
                        phase_next = PH_STRING;
                    end
                    else if (!(data_byte == " " || data_byte == 8'h09 ||
                               data_byte == 8'h0D || data_byte == 8'h0A))
                    begin
                        push     = 1'b1;
                        cmd.op   = OP_ERROR;
                        cmd.code = ERR_NO_QUOTE;
                    end
                end
            endcase
        end

        // any error returns the parser to idle
        if (push && cmd.op == OP_ERROR)
        begin
            phase_next       = PH_IDLE;
            digit_count_next = 2'd0;
            hex_accum_next   = 16'd0;
            high_bits_next   = 10'd0;
        end

        if (!accept)
        begin
            push = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            digit_count_reg <= 2'd0;
            hex_accum_reg   <= 16'd0;
            high_bits_reg   <= 10'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            digit_count_reg <= digit_count_next;
            hex_accum_reg   <= hex_accum_next;
            high_bits_reg   <= high_bits_next;
        end
    end

endmodule

// File: rtl/core/jsu_queue.sv
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::cmd_t push_cmd,
    input  logic          pop,
    output jsu_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          empty
);
    import jsu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// File: rtl/core/jsu_back.sv
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  jsu_pkg::cmd_t head_cmd,
    input  logic          head_valid,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output jsu_pkg::kind_t out_kind,
    output logic [7:0]    out_value,
    output jsu_pkg::err_t out_code,
    output logic          out_last
);
    import jsu_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] last_idx;
    logic       load;
    kind_t      kind_next;
    logic [7:0] value_next;
    err_t       code_next;
    logic       last_next;
    logic [CP_W-1:0] cp;

    logic       valid_reg;
    kind_t      kind_reg;
    logic [7:0] value_reg;
    err_t       code_reg;
    logic       last_reg;

    assign cp   = head_cmd.cp;
    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && (idx_reg == last_idx);

    // index of the last result transaction for the head command
    always_comb
    begin
        last_idx = 2'd0;
        if (head_cmd.op == OP_CODE_POINT)
        begin
            if (cp <= CP_W'(21'h7F))
            begin
                last_idx = 2'd0;
            end
            else if (cp <= CP_W'(21'h7FF))
            begin
                last_idx = 2'd1;
            end
            else if (cp <= CP_W'(21'hFFFF))
            begin
                last_idx = 2'd2;
            end
            else
            begin
                last_idx = 2'd3;
            end
        end
    end

    // one utf-8 byte or one end or error result
    always_comb
    begin
        kind_next  = KIND_DATA;
        value_next = 8'd0;
        code_next  = ERR_NO_QUOTE;
        last_next  = (idx_reg == last_idx);
        case (head_cmd.op)
            OP_BYTE:
            begin
                value_next = cp[7:0];
            end
            OP_END:
            begin
                kind_next = KIND_END;
            end
            OP_ERROR:
            begin
                kind_next = KIND_ERROR;
                code_next = head_cmd.code;
            end
            default:
            begin
                case ({last_idx, idx_reg})
                    4'b00_00: value_next = cp[7:0];
                    4'b01_00: value_next = {3'b110, cp[10:6]};
                    4'b01_01: value_next = {2'b10, cp[5:0]};
                    4'b10_00: value_next = {4'b1110, cp[15:12]};
                    4'b10_01: value_next = {2'b10, cp[11:6]};
                    4'b10_10: value_next = {2'b10, cp[5:0]};
                    4'b11_00: value_next = {5'b11110, cp[20:18]};
                    4'b11_01: value_next = {2'b10, cp[17:12]};
                    4'b11_10: value_next = {2'b10, cp[11:6]};
                    4'b11_11: value_next = {2'b10, cp[5:0]};
                    default:  value_next = 8'd0;
                endcase
            end
        endcase
    end

    // byte index within the current command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            idx_reg <= pop ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            code_reg  <= code_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_code  = code_reg;
    assign out_last  = last_reg;

endmodule

// File: rtl/core/json_string_unescape_top.sv
// channel  | direction | tdata                              | tuser          | tlast
// s_axis   | in        | [7:0] data_byte                    | end_of_input   | -
// m_axis   | out       | [7:0] value, [10:8] error_code     | [1:0] kind     | last
//
// one input byte is taken per cycle while the command queue has room
// a byte gives up to four result transactions, sent one per cycle while m_axis_tready
// is high, so the long-run rate is set by the output register: one result per cycle
// reset is asynchronous and active low; the parser returns to idle
// a stalled output fills the queue, after which s_axis_tready drops
module json_string_unescape_top #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] value, [10:8] error_code, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);
    import jsu_pkg::*;

    logic  accept;
    logic  push;
    cmd_t  push_cmd;
    cmd_t  head_cmd;
    logic  full;
    logic  empty;
    logic  pop;
    kind_t out_kind;
    logic [7:0] out_value;
    err_t  out_code;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    // front: parse and classify
    jsu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_axis_tdata),
        .end_of_input (s_axis_tuser),
        .push         (push),
        .cmd          (push_cmd)
    );

    // command queue
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (full),
        .empty    (empty)
    );

    // back: utf-8 encode and send
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (!empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (out_kind),
        .out_value  (out_value),
        .out_code   (out_code),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_code, out_value};
    assign m_axis_tuser = out_kind;

endmodule

// File: tb/testbench.sv
module testbench;

    import jsu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 230;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 20;

    // code field carried by data and end transactions
    localparam err_t NO_CODE = ERR_NO_QUOTE;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_STRING,
        SCAN_ESCAPE,
        SCAN_HEX1,
        SCAN_WANT_BS,
        SCAN_WANT_U,
        SCAN_HEX2
    } scan_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        err_t       code;
        logic       last;
    } result_t;

    // one input transaction, with an optional typed-in expectation
    typedef struct {
        logic [7:0] data;
        logic       eoi;
        bit         typed;
        kind_t      kind;
        logic [7:0] value;
        err_t       code;
    } row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // decoder state of the predictor
    scan_t       scan_phase = SCAN_IDLE;
    logic [1:0]  digit_cnt  = 2'd0;
    logic [15:0] hex_acc    = 16'h0000;
    logic [9:0]  high_bits  = 10'h000;

    result_t step_results[$];
    result_t due_results[$];
    row_t    stim_seq[$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    bit burst          = 1'b0;
    bit hold_output    = 1'b0;

    // directed rows: idle errors, raw extremes, escapes, surrogate pair, early end
    row_t directed_rows[] = '{
        '{8'h00, 1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_NO_QUOTE},
        '{"\t",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"A",   1'b0, 1'b1, KIND_ERROR, 8'h00, ERR_NO_QUOTE},
        '{"\"",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{8'h00, 1'b0, 1'b1, KIND_ERROR, 8'h00, ERR_CONTROL},
        '{"\"",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{8'hFF, 1'b0, 1'b1, KIND_DATA,  8'hFF, NO_CODE},
        '{8'h1F, 1'b0, 1'b1, KIND_ERROR, 8'h00, ERR_CONTROL},
        '{"\"",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"\\",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"x",   1'b0, 1'b1, KIND_ERROR, 8'h00, ERR_BAD_ESCAPE},
        '{"\"",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"\\",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"u",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"0",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"0",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"0",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"0",   1'b0, 1'b1, KIND_DATA,  8'h00, NO_CODE},
        '{"\\",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"u",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"d",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"B",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"f",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"F",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"\\",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"u",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"D",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"F",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"F",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"f",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"\"",  1'b0, 1'b1, KIND_END,   8'h00, NO_CODE},
        '{"\"",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"\\",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"u",   1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{"g",   1'b0, 1'b1, KIND_ERROR, 8'h00, ERR_BAD_HEX},
        '{"\"",  1'b0, 1'b0, KIND_DATA,  8'h00, NO_CODE},
        '{8'hA5, 1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_ENDED}
    };

    json_string_unescape_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void add_result(kind_t k, logic [7:0] v, err_t c);
        result_t r;
        r.kind  = k;
        r.value = v;
        r.code  = c;
        r.last  = 1'b0;
        step_results = {step_results, r};
    endfunction

    function automatic void parse_error(err_t c);
        add_result(KIND_ERROR, 8'h00, c);
        scan_phase = SCAN_IDLE;
        digit_cnt  = 2'd0;
        hex_acc    = 16'h0000;
        high_bits  = 10'h000;
    endfunction

    // code point to 1..4 utf-8 bytes
    function automatic void add_utf8(logic [20:0] cp);
        if (cp <= 21'h7F)
            add_result(KIND_DATA, cp[7:0], NO_CODE);
        else if (cp <= 21'h7FF)
        begin
            add_result(KIND_DATA, {3'b110, cp[10:6]}, NO_CODE);
            add_result(KIND_DATA, {2'b10, cp[5:0]}, NO_CODE);
        end
        else if (cp <= 21'hFFFF)
        begin
            add_result(KIND_DATA, {4'b1110, cp[15:12]}, NO_CODE);
            add_result(KIND_DATA, {2'b10, cp[11:6]}, NO_CODE);
            add_result(KIND_DATA, {2'b10, cp[5:0]}, NO_CODE);
        end
        else
        begin
            add_result(KIND_DATA, {5'b11110, cp[20:18]}, NO_CODE);
            add_result(KIND_DATA, {2'b10, cp[17:12]}, NO_CODE);
            add_result(KIND_DATA, {2'b10, cp[11:6]}, NO_CODE);
            add_result(KIND_DATA, {2'b10, cp[5:0]}, NO_CODE);
        end
    endfunction

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    // one input byte through the decoder, results left in step_results
    function automatic void unescape_step(logic [7:0] c, logic eoi);
        int          h;
        logic [15:0] acc;
        logic [7:0]  esc;
        step_results.delete();
        if (eoi)
        begin
            if (scan_phase == SCAN_IDLE)
                parse_error(ERR_NO_QUOTE);
            else
                parse_error(ERR_ENDED);
        end
        else
        begin
            case (scan_phase)
                SCAN_IDLE:
                begin
                    if (c == "\"")
                        scan_phase = SCAN_STRING;
                    else if (c != " " && c != "\t" && c != 8'h0D && c != 8'h0A)
                        parse_error(ERR_NO_QUOTE);
                end
                SCAN_STRING:
                begin
                    if (c == "\"")
                    begin
                        add_result(KIND_END, 8'h00, NO_CODE);
                        scan_phase = SCAN_IDLE;
                    end
                    else if (c < 8'h20)
                        parse_error(ERR_CONTROL);
                    else if (c == "\\")
                        scan_phase = SCAN_ESCAPE;
                    else
                        add_result(KIND_DATA, c, NO_CODE);
                end
                SCAN_ESCAPE:
                begin
                    case (c)
                        "\"", "\\", "/": esc = c;
                        "b":             esc = 8'h08;
                        "f":             esc = 8'h0C;
                        "n":             esc = 8'h0A;
                        "r":             esc = 8'h0D;
                        "t":             esc = 8'h09;
                        default:         esc = 8'hFF;
                    endcase
                    if (c == "u")
                    begin
                        scan_phase = SCAN_HEX1;
                        digit_cnt  = 2'd0;
                        hex_acc    = 16'h0000;
                    end
                    else if (esc == 8'hFF)
                        parse_error(ERR_BAD_ESCAPE);
                    else
                    begin
                        add_result(KIND_DATA, esc, NO_CODE);
                        scan_phase = SCAN_STRING;
                    end
                end
                SCAN_WANT_BS:
                begin
                    if (c != "\\")
                        parse_error(ERR_MISSING_U);
                    else
                        scan_phase = SCAN_WANT_U;
                end
                SCAN_WANT_U:
                begin
                    if (c != "u")
                        parse_error(ERR_MISSING_U);
                    else
                    begin
                        scan_phase = SCAN_HEX2;
                        digit_cnt  = 2'd0;
                        hex_acc    = 16'h0000;
                    end
                end
                default:
                begin
                    // four hex digits of the first or the second \u escape
                    h = hex_nibble(c);
                    if (h < 0)
                        parse_error(ERR_BAD_HEX);
                    else
                    begin
                        hex_acc = {hex_acc[11:0], h[3:0]};
                        if (digit_cnt != 2'd3)
                            digit_cnt = digit_cnt + 2'd1;
                        else
                        begin
                            digit_cnt = 2'd0;
                            acc       = hex_acc;
                            if (scan_phase == SCAN_HEX1)
                            begin
                                if (acc >= 16'hD800 && acc <= 16'hDBFF)
                                begin
                                    high_bits  = acc[9:0];
                                    hex_acc    = 16'h0000;
                                    scan_phase = SCAN_WANT_BS;
                                end
                                else if (acc >= 16'hDC00 && acc <= 16'hDFFF)
                                    parse_error(ERR_LONE_LOW);
                                else
                                begin
                                    hex_acc    = 16'h0000;
                                    scan_phase = SCAN_STRING;
                                    add_utf8({5'b0, acc});
                                end
                            end
                            else if (acc < 16'hDC00 || acc > 16'hDFFF)
                                parse_error(ERR_BAD_LOW);
                            else
                            begin
                                add_utf8(21'h10000 + {1'b0, high_bits, acc[9:0]});
                                hex_acc    = 16'h0000;
                                high_bits  = 10'h000;
                                scan_phase = SCAN_STRING;
                            end
                        end
                    end
                end
            endcase
        end
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // random sequence building
    // ---------------------------------------------------------------

    function automatic void put_item(logic [7:0] b, logic eoi);
        row_t r;
        r.data  = b;
        r.eoi   = eoi;
        r.typed = 1'b0;
        r.kind  = KIND_DATA;
        r.value = 8'h00;
        r.code  = NO_CODE;
        stim_seq = {stim_seq, r};
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'b0, n};
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'b0, n} - 8'd10;
    endfunction

    function automatic void put_u(logic [15:0] v);
        put_item("\\", 1'b0);
        put_item("u", 1'b0);
        put_item(hex_char(v[15:12]), 1'b0);
        put_item(hex_char(v[11:8]), 1'b0);
        put_item(hex_char(v[7:4]), 1'b0);
        put_item(hex_char(v[3:0]), 1'b0);
    endfunction

    function automatic logic [15:0] pick_bmp();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] pick_high();
        return 16'hD800 + 16'($urandom_range(0, 1023));
    endfunction

    // a quoted string with random content and a random ending
    function automatic void build_string();
        logic [7:0]  b;
        logic [15:0] v;
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0:       put_item(" ", 1'b0);
                1:       put_item("\t", 1'b0);
                2:       put_item(8'h0D, 1'b0);
                default: put_item(8'h0A, 1'b0);
            endcase
        end
        put_item("\"", 1'b0);
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    do
                        b = 8'($urandom_range(8'h20, 8'hFF));
                    while (b == "\"" || b == "\\");
                    put_item(b, 1'b0);
                end
                4, 5:
                begin
                    put_item("\\", 1'b0);
                    case ($urandom_range(0, 7))
                        0:       put_item("\"", 1'b0);
                        1:       put_item("\\", 1'b0);
                        2:       put_item("/", 1'b0);
                        3:       put_item("b", 1'b0);
                        4:       put_item("f", 1'b0);
                        5:       put_item("n", 1'b0);
                        6:       put_item("r", 1'b0);
                        default: put_item("t", 1'b0);
                    endcase
                end
                6, 7:
                    put_u(pick_bmp());
                default:
                begin
                    put_u(pick_high());
                    put_u(16'hDC00 + 16'($urandom_range(0, 1023)));
                end
            endcase
        end
        case ($urandom_range(0, 15))
            9:
                put_item(8'($urandom_range(8'h00, 8'h1F)), 1'b0);
            10:
            begin
                put_item("\\", 1'b0);
                do
                    b = 8'($urandom);
                while (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                       b == "n" || b == "r" || b == "t" || b == "u");
                put_item(b, 1'b0);
            end
            11:
            begin
                put_item("\\", 1'b0);
                put_item("u", 1'b0);
                repeat ($urandom_range(0, 3))
                    put_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
                do
                    b = 8'($urandom);
                while (hex_nibble(b) >= 0);
                put_item(b, 1'b0);
            end
            12:
                put_u(16'hDC00 + 16'($urandom_range(0, 1023)));
            13:
            begin
                // high surrogate not followed by a backslash and u
                put_u(pick_high());
                if ($urandom_range(0, 1))
                begin
                    do
                        b = 8'($urandom);
                    while (b == "\\");
                    put_item(b, 1'b0);
                end
                else
                begin
                    put_item("\\", 1'b0);
                    do
                        b = 8'($urandom);
                    while (b == "u");
                    put_item(b, 1'b0);
                end
            end
            14:
            begin
                put_u(pick_high());
                do
                    v = 16'($urandom);
                while (v >= 16'hDC00 && v <= 16'hDFFF);
                put_u(v);
            end
            15:
            begin
                // input ends part way through the string
                case ($urandom_range(0, 3))
                    0: ;
                    1: put_item("\\", 1'b0);
                    2:
                    begin
                        put_item("\\", 1'b0);
                        put_item("u", 1'b0);
                        repeat ($urandom_range(0, 3))
                            put_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
                    end
                    default:
                    begin
                        put_u(pick_high());
                        if ($urandom_range(0, 1))
                            put_item("\\", 1'b0);
                    end
                endcase
                put_item(8'($urandom), 1'b1);
            end
            default:
                put_item("\"", 1'b0);
        endcase
    endfunction

    // stray bytes and end markers outside any string
    function automatic void build_noise();
        repeat ($urandom_range(1, 3))
            put_item(8'($urandom), $urandom_range(0, 3) == 0);
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    task automatic send_item(row_t item);
        int      gap;
        result_t r;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item.data;
        s_axis_tuser  <= item.eoi;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        unescape_step(item.data, item.eoi);
        if (item.typed)
        begin
            r.kind  = item.kind;
            r.value = item.value;
            r.code  = item.code;
            r.last  = 1'b1;
            due_results = {due_results, r};
        end
        else
        begin
            due_results = {due_results, step_results};
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // output side and checking
    // ---------------------------------------------------------------

    initial
    begin
        int      stall;
        result_t got;
        result_t want;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                stall       = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            else if (burst)
                stall = 0;
            else
                stall = $urandom_range(0, 6);
            if (stall > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);

            // compare the transaction with the oldest expectation
            got.kind  = kind_t'(m_axis_tuser);
            got.value = m_axis_tdata[7:0];
            got.code  = err_t'(m_axis_tdata[10:8]);
            got.last  = m_axis_tlast;
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d value %02h code %0d last %0d",
                             got.kind, got.value, got.code, got.last);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.value !== want.value ||
                    got.code !== want.code || got.last !== want.last)
                begin
                    mismatch_count++;
                    // kind, value, code and last of each side
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d %02h %0d %0d, got %0d %02h %0d %0d",
                                 want.kind, want.value, want.code, want.last,
                                 got.kind, got.value, got.code, got.last);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        int random_sent;
        bit did_hold;
        bit did_drain;
        random_sent = 0;
        did_hold    = 1'b0;
        did_drain   = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // random part
        while (random_sent < RANDOM_ITEMS)
        begin
            stim_seq.delete();
            if ($urandom_range(0, 6) == 0)
                build_noise();
            else
                build_string();
            burst = ($urandom_range(0, 5) == 0);
            if (!did_hold && random_sent >= 60)
            begin
                // output stalled for a long stretch while input keeps coming
                did_hold    = 1'b1;
                burst       = 1'b1;
                hold_output = 1'b1;
            end
            else if (!did_drain && random_sent >= 150)
            begin
                did_drain = 1'b1;
                drain_results();
            end
            foreach (stim_seq[i])
                send_item(stim_seq[i]);
            random_sent += stim_seq.size();
        end
        burst = 1'b0;

        // wait for the tail of the output
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_queue.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_top.sv
tb/testbench.sv
